### hw/rtl/dcrc_pkg.sv
// ----------------------------------------------------------------------------
// dcrc_pkg
// Types, constants and helpers shared by the DMA channel register controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dcrc_pkg;

    // Default sizing
    localparam int DEF_CHANNELS      = 8;
    localparam int DEF_REQUEST_LINES = 32;

    // Per-input limit on start commands
    localparam int          CNT_W      = 4;
    localparam logic [3:0]  MAX_STARTS = 4'd8;

    // Control register bit positions
    localparam int EN_POS   = 16;
    localparam int SRST_POS = 19;
    localparam int DREQ_POS = 20;
    localparam int DIR_POS  = 26;
    localparam int PW_LO    = 27;
    localparam int IEN_POS  = 29;

    // Interrupt status bit positions
    localparam int FIN_POS  = 17;

    // Control bits kept in storage: DREQ and count live elsewhere
    localparam logic [31:0] CTRL_KEEP = 32'hFFEF_0000;

    // Register slots inside a channel window
    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_CTRL  = 3'd1;
    localparam logic [2:0] REG_PER   = 3'd2;
    localparam logic [2:0] REG_IRQ   = 3'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] CFG_BASE  = 1'b0;
    localparam logic [0:0] CFG_MAP   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LINE  = 2'd2,
        FUNC_DONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // One channel's register state
    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] ctrl;
        logic [15:0] count;
        logic [22:0] offset;
        logic [2:0]  burst;
        logic [17:0] irq;
    } t_chan;

    // Write request into the channel bank
    typedef struct packed {
        logic        we_start;
        logic        we_ctrl;
        logic        we_per;
        logic        we_irq;
        logic        done;
        logic [31:0] data;
    } t_bank_wr;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  channel;
        logic [31:0] rdata;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        direction;
        logic [2:0]  word_bytes;
        logic [15:0] word_count;
        logic [2:0]  burst;
        logic        last;
    } t_result;

    // Request line of a channel; channels above 7 use line 0
    function automatic logic [4:0] line_of(input logic [39:0] map, input logic [5:0] ch);
        logic [4:0] line;
        line = 5'd0;
        unique case (ch)
            6'd0:    line = map[4:0];
            6'd1:    line = map[9:5];
            6'd2:    line = map[14:10];
            6'd3:    line = map[19:15];
            6'd4:    line = map[24:20];
            6'd5:    line = map[29:25];
            6'd6:    line = map[34:30];
            6'd7:    line = map[39:35];
            default: line = 5'd0;
        endcase
        return line;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dcrc_if.sv
// ----------------------------------------------------------------------------
// dcrc_if
// Valid/ready channels of the DMA channel register controller: event input,
// result output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcrc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [9:0]  addr;
    logic [31:0] wdata;
    logic [4:0]  drq_line;
    logic        drq_level;
    logic [2:0]  done_channel;

    modport source (output valid, func, addr, wdata, drq_line, drq_level, done_channel,
                    input ready);
    modport sink   (input valid, func, addr, wdata, drq_line, drq_level, done_channel,
                    output ready);
endinterface

interface dcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  channel;
    logic [31:0] rdata;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        direction;
    logic [2:0]  word_bytes;
    logic [15:0] word_count;
    logic [2:0]  burst;
    logic        last;

    modport source (output valid, kind, channel, rdata, src_addr, dst_addr, direction,
                    word_bytes, word_count, burst, last, input ready);
    modport sink   (input valid, kind, channel, rdata, src_addr, dst_addr, direction,
                    word_bytes, word_count, burst, last, output ready);
endinterface

interface dcrc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dcrc_pkg::CFG_IDX_W-1:0]     index;
    logic [39:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/dcrc_bank.sv
// ----------------------------------------------------------------------------
// dcrc_bank
// Per-channel register state with one read port and one write port, both at
// the channel the sequencer points to.
// ----------------------------------------------------------------------------
`default_nettype none

module dcrc_bank #(
    parameter  int CHANNELS = dcrc_pkg::DEF_CHANNELS,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CH_W-1:0]    i_ch,
    input  wire dcrc_pkg::t_bank_wr i_wr,
    output dcrc_pkg::t_chan         o_rd
);

    dcrc_pkg::t_chan r_bank [CHANNELS];
    dcrc_pkg::t_chan n_entry;
    logic            wr_any;

    assign o_rd   = r_bank[i_ch];
    assign wr_any = i_wr.we_start | i_wr.we_ctrl | i_wr.we_per | i_wr.we_irq | i_wr.done;

    // Updated entry for the addressed channel
    always_comb begin
        n_entry = o_rd;
        if (i_wr.we_start) begin
            n_entry.start_addr = i_wr.data;
        end
        if (i_wr.we_ctrl) begin
            n_entry.ctrl  = i_wr.data & dcrc_pkg::CTRL_KEEP;
            n_entry.count = i_wr.data[15:0];
        end
        if (i_wr.we_per) begin
            n_entry.offset = i_wr.data[22:0];
            n_entry.burst  = i_wr.data[26:24];
        end
        if (i_wr.we_irq) begin
            n_entry.irq = {14'd0, i_wr.data[3:0]};
        end
        // finished transfer: drop EN and count, flag FIN when enabled
        if (i_wr.done) begin
            n_entry.count                     = 16'd0;
            n_entry.ctrl[dcrc_pkg::EN_POS]    = 1'b0;
            if (o_rd.ctrl[dcrc_pkg::IEN_POS]) begin
                n_entry.irq[dcrc_pkg::FIN_POS] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_bank[i] <= '0;
            end
        end else if (wr_any) begin
            r_bank[i_ch] <= n_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/dcrc_start.sv
// ----------------------------------------------------------------------------
// dcrc_start
// Start command builder shared by register writes and the request line scan:
// peripheral address adder, direction swap and word size decode.
// ----------------------------------------------------------------------------
`default_nettype none

module dcrc_start (
    input  wire logic [31:0]       i_base,
    input  wire dcrc_pkg::t_chan   i_chan,
    input  wire logic [2:0]        i_channel,
    output dcrc_pkg::t_result      o_res
);

    logic [31:0] per_addr;
    logic        dir;
    logic [1:0]  pw;
    logic [2:0]  bytes;

    assign per_addr = i_base + 32'({i_chan.offset, 2'b00});
    assign dir      = i_chan.ctrl[dcrc_pkg::DIR_POS];
    assign pw       = i_chan.ctrl[dcrc_pkg::PW_LO +: 2];

    // 4 >> pw, zero for the reserved code
    always_comb begin
        case (pw)
            2'd0:    bytes = 3'd4;
            2'd1:    bytes = 3'd2;
            2'd2:    bytes = 3'd1;
            default: bytes = 3'd0;
        endcase
    end

    always_comb begin
        o_res            = '0;
        o_res.kind       = dcrc_pkg::KIND_START;
        o_res.channel    = i_channel;
        o_res.src_addr   = dir ? per_addr : i_chan.start_addr;
        o_res.dst_addr   = dir ? i_chan.start_addr : per_addr;
        o_res.direction  = dir;
        o_res.word_bytes = bytes;
        o_res.word_count = i_chan.count;
        o_res.burst      = i_chan.burst;
        o_res.last       = 1'b0;
    end

endmodule

`default_nettype wire

### hw/rtl/dma_channel_register_controller.sv
// ----------------------------------------------------------------------------
// dma_channel_register_controller: bus reads/writes, line lowered, finished: one
// result, registered once the output is free; no new item until idle. Line
// raised: one channel a cycle bar output stalls, via the single bank read port.
// Synchronous active-low reset clears bank, state, config and line levels.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_channel_register_controller #(
    parameter int CHANNELS      = dcrc_pkg::DEF_CHANNELS,
    parameter int REQUEST_LINES = dcrc_pkg::DEF_REQUEST_LINES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dcrc_in_if.sink    i_in,
    dcrc_out_if.source o_out,
    dcrc_cfg_if.sink   i_cfg
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LW   = (REQUEST_LINES > 1) ? $clog2(REQUEST_LINES) : 1;

    // Control state
    dcrc_pkg::t_state r_state, n_state;
    logic                      r_out_v,  n_out_v;
    logic                      r_pend_v, n_pend_v;
    logic [dcrc_pkg::CNT_W-1:0] r_cnt,   n_cnt;
    logic [31:0]               r_base,   n_base;
    logic [39:0]               r_map,    n_map;
    logic [REQUEST_LINES-1:0]  r_req,    n_req;

    // Item and result payload
    dcrc_pkg::t_func   r_func,  n_func;
    logic [9:0]        r_addr,  n_addr;
    logic [31:0]       r_wdata, n_wdata;
    logic [4:0]        r_dl,    n_dl;
    logic              r_lv,    n_lv;
    logic [CH_W-1:0]   r_ch,    n_ch;
    logic              r_ok,    n_ok;
    dcrc_pkg::t_result r_pend,  n_pend;
    dcrc_pkg::t_result r_out,   n_out;

    dcrc_pkg::t_chan   bank_rd;
    dcrc_pkg::t_chan   start_in;
    dcrc_pkg::t_bank_wr bank_wr;
    dcrc_pkg::t_result start_res;
    dcrc_pkg::t_result exec_res;
    dcrc_pkg::t_result reply_res;

    logic        in_fire;
    logic        out_free;
    dcrc_pkg::t_func in_func;
    logic [5:0]  in_ch6;
    logic [5:0]  in_dc6;
    logic        in_bus_ok;
    logic        in_line_ok;
    logic [4:0]  ch_line;
    logic        ch_high;
    logic        ch_last;
    logic [2:0]  reg_sel;
    logic        exec_fire;
    logic        flush_fire;
    logic        scan_match;
    logic        scan_stall;
    logic        scan_step;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    dcrc_bank #(
        .CHANNELS (CHANNELS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ch    (r_ch),
        .i_wr    (bank_wr),
        .o_rd    (bank_rd)
    );

    dcrc_start u_start (
        .i_base    (r_base),
        .i_chan    (start_in),
        .i_channel (3'(r_ch)),
        .o_res     (start_res)
    );

    // ------------------------------------------------------------------
    // Handshakes and decode
    // ------------------------------------------------------------------
    assign i_in.ready  = (r_state == dcrc_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_v || o_out.ready;

    assign in_func    = dcrc_pkg::t_func'(i_in.func);
    assign in_ch6     = {1'b0, i_in.addr[9:5]};
    assign in_dc6     = {3'b000, i_in.done_channel};
    assign in_bus_ok  = (i_in.addr[1:0] == 2'b00) && (in_ch6 < 6'(CHANNELS));
    assign in_line_ok = ({1'b0, i_in.drq_line} < 6'(REQUEST_LINES));

    // Request line of the addressed channel and its level
    assign ch_line = dcrc_pkg::line_of(r_map, 6'(r_ch));
    assign ch_high = ({1'b0, ch_line} < 6'(REQUEST_LINES)) && r_req[ch_line[LW-1:0]];
    assign ch_last = (r_ch == CH_W'(CHANNELS - 1));
    assign reg_sel = r_addr[4:2];

    assign exec_fire  = (r_state == dcrc_pkg::ST_EXEC) && out_free;
    assign flush_fire = (r_state == dcrc_pkg::ST_FLUSH) && out_free;

    // Scan: channel mapped to the raised line with EN set, under the start limit
    assign scan_match = (r_state == dcrc_pkg::ST_SCAN) && (ch_line == r_dl)
                        && bank_rd.ctrl[dcrc_pkg::EN_POS] && (r_cnt < dcrc_pkg::MAX_STARTS);
    assign scan_stall = scan_match && r_pend_v && !out_free;
    assign scan_step  = (r_state == dcrc_pkg::ST_SCAN) && !scan_stall;

    // Builder input: a control write starts from the new control word
    always_comb begin
        start_in = bank_rd;
        if (r_state == dcrc_pkg::ST_EXEC) begin
            start_in.ctrl  = r_wdata & dcrc_pkg::CTRL_KEEP;
            start_in.count = r_wdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Single-result execution of bus accesses, line lowered and finished
    // ------------------------------------------------------------------
    always_comb begin
        reply_res      = '0;
        reply_res.kind = dcrc_pkg::KIND_REPLY;
        reply_res.last = 1'b1;
        exec_res       = reply_res;
        bank_wr        = '0;
        bank_wr.data   = r_wdata;
        case (r_func)
            dcrc_pkg::FUNC_READ: begin
                if (r_ok) begin
                    unique case (reg_sel)
                        dcrc_pkg::REG_START: exec_res.rdata = bank_rd.start_addr;
                        dcrc_pkg::REG_CTRL: begin
                            exec_res.rdata = bank_rd.ctrl | 32'(bank_rd.count);
                            exec_res.rdata[dcrc_pkg::DREQ_POS] = ch_high;
                        end
                        dcrc_pkg::REG_PER:
                            exec_res.rdata = {5'd0, bank_rd.burst, 1'b0, bank_rd.offset};
                        dcrc_pkg::REG_IRQ:   exec_res.rdata = 32'(bank_rd.irq);
                        default:             exec_res.rdata = 32'd0;
                    endcase
                end
            end
            dcrc_pkg::FUNC_WRITE: begin
                if (r_ok) begin
                    unique case (reg_sel)
                        dcrc_pkg::REG_START: bank_wr.we_start = exec_fire;
                        dcrc_pkg::REG_CTRL: begin
                            bank_wr.we_ctrl = exec_fire;
                            if (r_wdata[dcrc_pkg::SRST_POS]) begin
                                exec_res.kind    = dcrc_pkg::KIND_STOP;
                                exec_res.channel = 3'(r_ch);
                            end else if (bank_rd.ctrl[dcrc_pkg::EN_POS]
                                         != r_wdata[dcrc_pkg::EN_POS]) begin
                                if (!r_wdata[dcrc_pkg::EN_POS]) begin
                                    exec_res.kind    = dcrc_pkg::KIND_STOP;
                                    exec_res.channel = 3'(r_ch);
                                end else if (ch_high) begin
                                    exec_res      = start_res;
                                    exec_res.last = 1'b1;
                                end
                            end
                        end
                        dcrc_pkg::REG_PER:   bank_wr.we_per = exec_fire;
                        dcrc_pkg::REG_IRQ:   bank_wr.we_irq = exec_fire;
                        default:             bank_wr.we_irq = 1'b0;
                    endcase
                end
            end
            dcrc_pkg::FUNC_DONE: bank_wr.done = exec_fire && r_ok;
            default:             bank_wr.done = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dcrc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_func == dcrc_pkg::FUNC_LINE && i_in.drq_level && in_line_ok) begin
                        n_state = dcrc_pkg::ST_SCAN;
                    end else begin
                        n_state = dcrc_pkg::ST_EXEC;
                    end
                end
            end
            dcrc_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = dcrc_pkg::ST_IDLE;
                end
            end
            dcrc_pkg::ST_SCAN: begin
                if (scan_step && ch_last) begin
                    n_state = dcrc_pkg::ST_FLUSH;
                end
            end
            dcrc_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = dcrc_pkg::ST_IDLE;
                end
            end
            default: n_state = dcrc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        n_func   = r_func;
        n_addr   = r_addr;
        n_wdata  = r_wdata;
        n_dl     = r_dl;
        n_lv     = r_lv;
        n_ch     = r_ch;
        n_ok     = r_ok;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !o_out.ready;
        n_base   = r_base;
        n_map    = r_map;
        n_req    = r_req;

        // configuration writes
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dcrc_pkg::CFG_BASE: n_base = i_cfg.data[31:0];
                dcrc_pkg::CFG_MAP:  n_map  = i_cfg.data;
                default:            n_map  = r_map;
            endcase
        end

        // capture an accepted item
        if (in_fire) begin
            n_func   = in_func;
            n_addr   = i_in.addr;
            n_wdata  = i_in.wdata;
            n_dl     = i_in.drq_line;
            n_lv     = i_in.drq_level;
            n_cnt    = '0;
            n_pend_v = 1'b0;
            case (in_func)
                dcrc_pkg::FUNC_LINE: begin
                    n_ch = '0;
                    n_ok = in_line_ok;
                end
                dcrc_pkg::FUNC_DONE: begin
                    n_ch = in_dc6[CH_W-1:0];
                    n_ok = (in_dc6 < 6'(CHANNELS));
                end
                default: begin
                    n_ch = in_ch6[CH_W-1:0];
                    n_ok = in_bus_ok;
                end
            endcase
        end

        // single result, line lowered records the new level
        if (exec_fire) begin
            n_out_v = 1'b1;
            n_out   = exec_res;
            if (r_func == dcrc_pkg::FUNC_LINE && r_ok && !r_lv) begin
                n_req[r_dl[LW-1:0]] = 1'b0;
            end
        end

        // scan step: a new start pushes the held one out
        if (scan_step) begin
            if (scan_match) begin
                if (r_pend_v) begin
                    n_out_v = 1'b1;
                    n_out   = r_pend;
                end
                n_pend   = start_res;
                n_pend_v = 1'b1;
                n_cnt    = r_cnt + 1'b1;
            end
            if (!ch_last) begin
                n_ch = r_ch + 1'b1;
            end
        end

        // end of scan: final result and the line goes high
        if (flush_fire) begin
            n_out_v = 1'b1;
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out.last = 1'b1;
            end else begin
                n_out = reply_res;
            end
            n_pend_v            = 1'b0;
            n_req[r_dl[LW-1:0]] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dcrc_pkg::ST_IDLE;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_base   <= '0;
            r_map    <= '0;
            r_req    <= '0;
        end else begin
            r_state  <= n_state;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
            r_base   <= n_base;
            r_map    <= n_map;
            r_req    <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_addr  <= n_addr;
        r_wdata <= n_wdata;
        r_dl    <= n_dl;
        r_lv    <= n_lv;
        r_ch    <= n_ch;
        r_ok    <= n_ok;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign o_out.valid      = r_out_v;
    assign o_out.kind       = r_out.kind;
    assign o_out.channel    = r_out.channel;
    assign o_out.rdata      = r_out.rdata;
    assign o_out.src_addr   = r_out.src_addr;
    assign o_out.dst_addr   = r_out.dst_addr;
    assign o_out.direction  = r_out.direction;
    assign o_out.word_bytes = r_out.word_bytes;
    assign o_out.word_count = r_out.word_count;
    assign o_out.burst      = r_out.burst;
    assign o_out.last       = r_out.last;

`ifndef SYNTHESIS
    // start count never passes the per-item limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dcrc_pkg::MAX_STARTS)
        else $error("start count above limit");

    // a held start exists only while a scan is in progress
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == dcrc_pkg::ST_SCAN || r_state == dcrc_pkg::ST_FLUSH))
        else $error("held start outside scan");

    // a non-final result is always followed by a held one
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.last) |-> r_pend_v)
        else $error("non-final result without a successor");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != dcrc_pkg::ST_IDLE))
        else $error("accepted item dropped");
`endif

endmodule

`default_nettype wire
